// File: src/mwa_pkg.sv
// Moving window average: shared widths, register indexes and constants.
// No dependencies; every other file of the block but mwa_div refers to it by scoped names.
`default_nettype none

package mwa_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int SUM_W      = 40;
	localparam int AVG_W      = 40;
	localparam int FILL_W     = 9;
	localparam int WLEN_W     = 9;
	localparam int PERIOD_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [WLEN_W-1:0]   WLEN_RESET = 9'd256;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
	localparam logic [AVG_W-1:0]    AVG_MAX    = 40'hFF_FFFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_AVG_PERIOD    = 2'd1
	} cfg_reg_t;

endpackage

`default_nettype wire

// File: src/mwa_if.sv
// Channel interfaces of the moving window average: sample input, result output
// and configuration write. Depends on mwa_pkg for field widths.
`default_nettype none

interface mwa_in_if;
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic [mwa_pkg::SAMPLE_W-1:0] sample_value;

	modport source (output valid, output action, output sample_value, input ready);
	modport sink   (input valid, input action, input sample_value, output ready);
endinterface

interface mwa_out_if;
	logic                       valid;
	logic                       ready;
	logic [mwa_pkg::AVG_W-1:0]  average_value;
	logic                       average_updated;
	logic [mwa_pkg::SUM_W-1:0]  window_sum;
	logic [mwa_pkg::FILL_W-1:0] fill_level;
	logic                       window_full;

	modport source (output valid, output average_value, output average_updated,
		output window_sum, output fill_level, output window_full, input ready);
	modport sink   (input valid, input average_value, input average_updated,
		input window_sum, input fill_level, input window_full, output ready);
endinterface

interface mwa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [mwa_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [mwa_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// File: src/moving_window_average.sv
// Moving window average over a ring of recent samples, top level.
// Depends on mwa_pkg, the channel interfaces in mwa_if and the divider mwa_div.
//
//   channel   modport  beat carries
//   cfg       sink     reg_index, wdata (window_length, avg_period)
//   samples   sink     action, sample_value
//   results   source   average_value, average_updated, window_sum,
//                      fill_level, window_full
//
// A sample beat passes through the ring read, the update and the result step when no
// average is due, and through the divider between update and result when one is; a clear
// goes straight to the result step. The ring is a single-port-read memory with a
// registered read; the divider produces one quotient bit per cycle.
// Reset clears all control state; ring entries are undefined until written.
// A waiting result holds the block in its final step until results is taken.
// A cfg beat is taken only while idle and holds off sample beats in that cycle.
`default_nettype none

module moving_window_average #(
	parameter int MAX_DEPTH   = 256,
	parameter int SAMPLE_BITS = 32,
	parameter int FRAC_BITS   = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mwa_cfg_if.sink    cfg,
	mwa_in_if.sink     samples,
	mwa_out_if.source  results
);

	localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int PTR_W = $clog2(MAX_DEPTH + 1);
	localparam int DIV_W = mwa_pkg::SUM_W + FRAC_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	logic [mwa_pkg::WLEN_W-1:0]   wlen_q;
	logic [mwa_pkg::PERIOD_W-1:0] period_q;
	logic [IDX_W-1:0]             wi_q;
	logic [PTR_W-1:0]             fill_q;
	logic [mwa_pkg::SUM_W-1:0]    sum_q;
	logic [mwa_pkg::PERIOD_W-1:0] pcnt_q;
	logic [mwa_pkg::AVG_W-1:0]    held_q;
	logic                         upd_q;
	logic [IDX_W-1:0]             wi_s1;
	logic [SAMPLE_BITS-1:0]       sample_s1;
	logic [SAMPLE_BITS-1:0]       rdata_s1;

	logic                         out_valid_q;
	logic [mwa_pkg::AVG_W-1:0]    out_avg_q;
	logic                         out_upd_q;
	logic [mwa_pkg::SUM_W-1:0]    out_sum_q;
	logic [mwa_pkg::FILL_W-1:0]   out_fill_q;
	logic                         out_full_q;

	logic [SAMPLE_BITS-1:0] ring [MAX_DEPTH];

	logic [PTR_W-1:0]             len;
	logic [IDX_W-1:0]             wi_cur;
	logic                         was_full;
	logic [mwa_pkg::SUM_W-1:0]    sum_base;
	logic [mwa_pkg::SUM_W-1:0]    sum_new;
	logic [PTR_W-1:0]             fill_new;
	logic [PTR_W-1:0]             wi_inc;
	logic [IDX_W-1:0]             wi_next;
	logic [mwa_pkg::PERIOD_W-1:0] pcnt_inc;
	logic                         do_update;
	logic                         div_start;
	logic                         div_done;
	logic [DIV_W-1:0]             div_quot;
	logic                         in_acc;
	logic                         out_free;
	logic                         ring_we;

	always_comb begin
		if (32'(wlen_q) > MAX_DEPTH) begin
			len = PTR_W'(MAX_DEPTH);
		end else if (wlen_q == '0) begin
			len = PTR_W'(1);
		end else begin
			len = PTR_W'(wlen_q);
		end

		wi_cur   = (PTR_W'(wi_q) >= len) ? '0 : wi_q;
		was_full = (fill_q >= len);
		sum_base = was_full ? (sum_q - mwa_pkg::SUM_W'(rdata_s1)) : sum_q;
		sum_new  = sum_base + mwa_pkg::SUM_W'(sample_s1);
		fill_new = was_full ? len : (fill_q + 1'b1);
		wi_inc   = PTR_W'(wi_s1) + 1'b1;
		wi_next  = (wi_inc >= len) ? '0 : IDX_W'(wi_inc);
		pcnt_inc = (pcnt_q < mwa_pkg::PERIOD_MAX) ? (pcnt_q + 1'b1) : pcnt_q;
		do_update = (period_q != '0) && (pcnt_inc >= period_q) && (sum_new != '0);

		in_acc    = samples.valid && samples.ready;
		out_free  = !out_valid_q || results.ready;
		div_start = (state_q == ST_READ) && do_update;
		ring_we   = (state_q == ST_READ);
	end

	assign samples.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign cfg.ready     = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[wi_s1] <= sample_s1;
		end
		rdata_s1 <= ring[wi_cur];
	end

	mwa_div #(
		.DW (DIV_W),
		.VW (PTR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIV_W'(sum_new) << FRAC_BITS),
		.divisor  (fill_new),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			wi_s1     <= wi_cur;
			sample_s1 <= samples.sample_value[SAMPLE_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wlen_q      <= mwa_pkg::WLEN_RESET;
			period_q    <= '0;
			wi_q        <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			pcnt_q      <= '0;
			held_q      <= '0;
			upd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					mwa_pkg::REG_WINDOW_LENGTH: begin
						wlen_q <= cfg.wdata[mwa_pkg::WLEN_W-1:0];
						wi_q   <= '0;
						fill_q <= '0;
						sum_q  <= '0;
						pcnt_q <= '0;
					end
					mwa_pkg::REG_AVG_PERIOD: begin
						period_q <= cfg.wdata;
					end
					default: begin
					end
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						upd_q <= 1'b0;
						if (samples.action) begin
							wi_q    <= '0;
							fill_q  <= '0;
							sum_q   <= '0;
							pcnt_q  <= '0;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					sum_q  <= sum_new;
					fill_q <= fill_new;
					wi_q   <= wi_next;
					if (period_q != '0) begin
						pcnt_q <= do_update ? '0 : pcnt_inc;
					end
					if (do_update) begin
						upd_q   <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						held_q  <= (div_quot > DIV_W'(mwa_pkg::AVG_MAX)) ?
							mwa_pkg::AVG_MAX : mwa_pkg::AVG_W'(div_quot);
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_avg_q  <= held_q;
			out_upd_q  <= upd_q;
			out_sum_q  <= sum_q;
			out_fill_q <= mwa_pkg::FILL_W'(fill_q);
			out_full_q <= (fill_q == len);
		end
	end

	assign results.valid           = out_valid_q;
	assign results.average_value   = out_avg_q;
	assign results.average_updated = out_upd_q;
	assign results.window_sum      = out_sum_q;
	assign results.fill_level      = out_fill_q;
	assign results.window_full     = out_full_q;

endmodule

`default_nettype wire

// File: src/mwa_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Self-contained; used by moving_window_average.
`default_nettype none

module mwa_div #(
	parameter int DW = 48,
	parameter int VW = 9
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      quot
);

	localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [DW-1:0]    shreg_q;

	logic [VW:0] trial;
	logic [VW:0] diff;
	logic        ge;

	always_comb begin
		trial = {rem_q, shreg_q[DW-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			dvs_q   <= divisor;
			shreg_q <= dividend;
		end else if (busy_q) begin
			rem_q   <= ge ? diff[VW-1:0] : trial[VW-1:0];
			shreg_q <= {shreg_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = shreg_q;

endmodule

`default_nettype wire

// File: src/mwa_checker.sv
// Port-level checks for moving_window_average, attached by the bind below.
// Depends on mwa_pkg for field widths and on the top level's channel ports.
`default_nettype none

module mwa_port_checks (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic [mwa_pkg::AVG_W-1:0]  out_avg,
	input wire logic                       out_upd,
	input wire logic [mwa_pkg::SUM_W-1:0]  out_sum,
	input wire logic [mwa_pkg::FILL_W-1:0] out_fill
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_avg) && $stable(out_sum))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_acc)
		else $error("sample beat accepted while previous one in work");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(out_valid))
		else $error("result beat appeared one cycle after sample beat");

	a_update_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_upd |-> (out_sum != '0) && (out_fill != '0))
		else $error("average update with empty window");

endmodule

bind moving_window_average mwa_port_checks u_mwa_port_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_avg   (results.average_value),
	.out_upd   (results.average_updated),
	.out_sum   (results.window_sum),
	.out_fill  (results.fill_level)
);

`default_nettype wire

// File: tb/mwa_checker.sv
// Scoreboard for the moving window average: mirrors the ring, running sum and
// averaging period, and checks every result beat. Depends on mwa_pkg and mwa_if.
`default_nettype none

module mwa_checker (
	input  wire logic clk,
	input  wire logic arst_n,
	mwa_cfg_if   cfg,
	mwa_in_if    samples,
	mwa_out_if   results,
	output int   mismatch_count,
	output int   results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH = 256;

	typedef struct packed {
		logic [mwa_pkg::AVG_W-1:0]  avg;
		logic                       updated;
		logic [mwa_pkg::SUM_W-1:0]  sum;
		logic [mwa_pkg::FILL_W-1:0] fill;
		logic                       full;
	} window_result_t;

	logic [mwa_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
	logic [7:0]                   next_slot;
	logic [mwa_pkg::FILL_W-1:0]   held_count;
	logic [mwa_pkg::SUM_W-1:0]    sum_acc;
	logic [mwa_pkg::PERIOD_W-1:0] adds_since_avg;
	logic [mwa_pkg::AVG_W-1:0]    avg_hold;
	logic [mwa_pkg::WLEN_W-1:0]   span_reg;
	logic [mwa_pkg::PERIOD_W-1:0] period_reg;

	window_result_t window_results_due [$];

	function automatic logic [mwa_pkg::FILL_W-1:0] window_span();
		if (span_reg == '0)
			return 9'd1;
		if (span_reg > RING_DEPTH)
			return 9'(RING_DEPTH);
		return span_reg;
	endfunction

	function automatic void empty_window();
		next_slot      = '0;
		held_count     = '0;
		sum_acc        = '0;
		adds_since_avg = '0;
	endfunction

	function automatic window_result_t advance_window(logic act,
			logic [mwa_pkg::SAMPLE_W-1:0] value);
		logic [mwa_pkg::FILL_W-1:0] span;
		logic [7:0]                 slot;
		logic [47:0]                quot;
		window_result_t             r;
		span      = window_span();
		r.updated = 1'b0;
		if (act) begin
			empty_window();
		end else begin
			slot = ({1'b0, next_slot} >= span) ? 8'd0 : next_slot;
			if (held_count >= span) begin
				sum_acc    = sum_acc - {8'd0, ring[slot]};
				held_count = span;
			end else begin
				held_count = held_count + 9'd1;
			end
			ring[slot] = value;
			sum_acc    = sum_acc + {8'd0, value};
			next_slot  = ({1'b0, slot} + 9'd1 >= span) ? 8'd0 : slot + 8'd1;
			if (period_reg != '0) begin
				if (adds_since_avg != mwa_pkg::PERIOD_MAX)
					adds_since_avg = adds_since_avg + 16'd1;
				if (adds_since_avg >= period_reg && sum_acc != '0) begin
					quot           = {sum_acc, 8'd0} / {39'd0, held_count};
					adds_since_avg = '0;
					avg_hold       = (quot > {8'd0, mwa_pkg::AVG_MAX}) ?
						mwa_pkg::AVG_MAX : quot[mwa_pkg::AVG_W-1:0];
					r.updated      = 1'b1;
				end
			end
		end
		r.avg  = avg_hold;
		r.sum  = sum_acc;
		r.fill = held_count;
		r.full = (held_count == span);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		window_result_t seen;
		window_result_t want;
		if (!arst_n) begin
			empty_window();
			avg_hold       = '0;
			span_reg       = mwa_pkg::WLEN_RESET;
			period_reg     = '0;
			mismatch_count = 0;
			window_results_due.delete();
			foreach (ring[i])
				ring[i] = '0;
		end else begin
			if (results.valid && results.ready) begin
				seen = '{results.average_value, results.average_updated, results.window_sum,
					results.fill_level, results.window_full};
				if (window_results_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%t: result beat with nothing due: avg %h sum %h fill %0d",
							$realtime, seen.avg, seen.sum, seen.fill);
				end else begin
					want = window_results_due.pop_front();
					if (seen.avg !== want.avg || seen.updated !== want.updated ||
							seen.sum !== want.sum || seen.fill !== want.fill ||
							seen.full !== want.full) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%t: result mismatch (expected/actual): avg %h/%h ",
								"updated %b/%b sum %h/%h fill %0d/%0d full %b/%b"},
								$realtime, want.avg, seen.avg, want.updated, seen.updated,
								want.sum, seen.sum, want.fill, seen.fill, want.full, seen.full);
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.reg_index)
					mwa_pkg::REG_WINDOW_LENGTH: begin
						span_reg = cfg.wdata[mwa_pkg::WLEN_W-1:0];
						empty_window();
					end
					mwa_pkg::REG_AVG_PERIOD: period_reg = cfg.wdata[mwa_pkg::PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (samples.valid && samples.ready)
				window_results_due.push_back(advance_window(samples.action, samples.sample_value));
		end
		results_due = window_results_due.size();
	end

endmodule

`default_nettype wire

// File: tb/tb_moving_window_average.sv
// Testbench top for the moving window average: clock, reset, configuration
// and sample stimulus, result back-pressure and the verdict. Depends on
// mwa_pkg, mwa_if, moving_window_average and mwa_checker.
`default_nettype none

module tb_moving_window_average;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   results_due;
	bit   gaps_on;
	bit   hold_results;

	mwa_cfg_if cfg_ch ();
	mwa_in_if  samples_ch ();
	mwa_out_if results_ch ();

	moving_window_average i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.samples (samples_ch),
		.results (results_ch)
	);

	mwa_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_ch),
		.samples        (samples_ch),
		.results        (results_ch),
		.mismatch_count (mismatch_count),
		.results_due    (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// hold off the result channel for a long stretch on request
	initial begin
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				results_ch.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_results = 1'b0;
			end
			results_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 23);
		end
	end

	function automatic logic [mwa_pkg::SAMPLE_W-1:0] draw_sample();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return mwa_pkg::SAMPLE_W'($urandom_range(0, 255));
			default: return $urandom();
		endcase
	endfunction

	task automatic send_sample(input logic act, input logic [mwa_pkg::SAMPLE_W-1:0] value);
		while (gaps_on && $urandom_range(0, 99) < 23) begin
			samples_ch.valid <= 1'b0;
			@(negedge clk);
		end
		samples_ch.valid        <= 1'b1;
		samples_ch.action       <= act;
		samples_ch.sample_value <= value;
		do @(posedge clk); while (!samples_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		samples_ch.valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	task automatic write_register(input mwa_pkg::cfg_reg_t idx,
			input logic [mwa_pkg::CFG_DATA_W-1:0] value);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= idx;
		cfg_ch.wdata     <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	task automatic configure(input logic [mwa_pkg::WLEN_W-1:0] span,
			input logic [mwa_pkg::PERIOD_W-1:0] period);
		wait_drained();
		write_register(mwa_pkg::REG_WINDOW_LENGTH, mwa_pkg::CFG_DATA_W'(span));
		write_register(mwa_pkg::REG_AVG_PERIOD, period);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [mwa_pkg::WLEN_W-1:0] span,
			input logic [mwa_pkg::PERIOD_W-1:0] period,
			input int count, input int clear_pct, input bit with_hold);
		configure(span, period);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 30)
				hold_results = 1'b1;
			send_sample($urandom_range(0, 99) < clear_pct, draw_sample());
		end
	endtask

	initial begin
		arst_n                  = 1'b0;
		gaps_on                 = 1'b1;
		hold_results            = 1'b0;
		samples_ch.valid        = 1'b0;
		samples_ch.action       = 1'b0;
		samples_ch.sample_value = '0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.reg_index        = mwa_pkg::REG_WINDOW_LENGTH;
		cfg_ch.wdata            = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_sample(1'b0, '0);
		send_sample(1'b0, '1);
		send_sample(1'b0, 32'd1);
		send_sample(1'b1, $urandom());
		send_sample(1'b0, 32'd5);

		configure(9'd3, 16'd1);
		repeat (4) send_sample(1'b0, '1);
		send_sample(1'b0, '0);
		send_sample(1'b0, 32'd2);

		send_sample(1'b1, '0);
		send_sample(1'b0, '0);
		send_sample(1'b0, '0);
		send_sample(1'b0, 32'd7);

		// lower the period below the running count
		configure(9'd2, 16'd40);
		repeat (6) send_sample(1'b0, 32'd10);
		wait_drained();
		write_register(mwa_pkg::REG_AVG_PERIOD, 16'd3);
		cfg_ch.valid <= 1'b0;
		send_sample(1'b0, 32'd11);

		configure(9'd0, 16'd2);
		repeat (3) send_sample(1'b0, draw_sample());
		configure(9'd511, 16'd1);
		repeat (3) send_sample(1'b0, draw_sample());

		run_phase(9'd1, 16'd1, 60, 5, 1'b0);
		run_phase(9'd2, 16'd0, 60, 5, 1'b0);
		run_phase(9'd17, 16'd3, 100, 3, 1'b0);
		run_phase(9'd256, 16'd5, 290, 0, 1'b1);
		run_phase(9'd300, 16'd2, 60, 5, 1'b0);
		run_phase(9'd5, 16'hFFFF, 60, 5, 1'b0);
		run_phase(9'd64, 16'd20, 80, 2, 1'b0);
		run_phase(9'($urandom_range(1, 256)), 16'($urandom_range(1, 12)), 80, 4, 1'b0);

		// hold a zero sum past the period end, then add a nonzero sample and random ones
		configure(9'd4, 16'd3);
		gaps_on = 1'b0;
		repeat (6) send_sample(1'b0, '0);
		send_sample(1'b0, 32'd9);
		repeat (30) send_sample(1'b0, draw_sample());
		gaps_on = 1'b1;

		wait_drained();
		repeat (60) @(negedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
src/mwa_pkg.sv
src/mwa_if.sv
src/mwa_div.sv
src/moving_window_average.sv
src/mwa_checker.sv
tb/mwa_checker.sv
tb/tb_moving_window_average.sv
